// File: design/assert_macros.svh
// shared assertion macros for the weight stability detector checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define WSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define WSD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: design/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

    // window geometry
    localparam int WINDOW_MAX = 32;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // field widths
    localparam int SAMPLE_W   = 21;
    localparam int MAG_W      = 20;
    localparam int TOL_W      = 14;
    localparam int TICK_W     = 20;
    localparam int LEN_CFG_W  = 6;
    localparam int OP_W       = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    // window sum and serial divider
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    // stream widths
    localparam int IN_TDATA_W   = ((SAMPLE_W + MAG_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = OP_W;
    localparam int OUT_TDATA_W  = ((SAMPLE_W + 1 + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = KIND_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_SAMPLE   = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd1;
    localparam logic [OP_W-1:0] OP_START    = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTINUE = 3'd3;
    localparam logic [OP_W-1:0] OP_CANCEL   = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_READING = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEAN    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SAMPLES = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_TICKS  = 2'd2;

    // register reset values
    localparam logic [LEN_CFG_W-1:0] WINDOW_SAMPLES_RST = 6'd10;
    localparam logic [TOL_W-1:0]     TOLERANCE_RST      = 14'd5;
    localparam logic [TICK_W-1:0]    TIMEOUT_TICKS_RST  = 20'd15000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] weight;
        logic                       stable;
        logic                       last;
    } t_result;

    localparam t_result RES_TIMEOUT = '{
        kind:   KIND_TIMEOUT,
        weight: '0,
        stable: 1'b0,
        last:   1'b1
    };

    // window length from the register, held to 1..WINDOW_MAX
    function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_CFG_W-1:0] v);
        int t;
        t = int'(v);
        if (t < 1) begin
            t = 1;
        end
        if (t > WINDOW_MAX) begin
            t = WINDOW_MAX;
        end
        return CNT_W'(t);
    endfunction

endpackage

`default_nettype wire

// File: design/weight_stability_detector.sv
// channel   dir  tdata (low bit up)                        tuser     tlast
// s_axis    in   sample_weight[20:0] min_magnitude[40:21]   opcode    -
// m_axis    out  weight_out[20:0] is_stable[21]            kind      last
// cfg       in   i_cfg_addr = register index, i_cfg_wdata = value, i_cfg_we
//
// tick, start, continue, cancel and a sample that leaves the window short are
// decided in the idle state; each result then passes through the output register.
// a sample that fills the window rotates the 32-cell chain once, judges the
// spread and, when stable, runs the serial divider for the mean before the
// first result.
// synchronous active-low reset clears control state; window cells hold junk
// until written. a stalled output holds its item and blocks further work.
`default_nettype none

module weight_stability_detector (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input items
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // sample_weight[20:0], min_magnitude[40:21], zero pad
    input  wire logic [wsd_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // opcode[2:0]
    input  wire logic [wsd_pkg::IN_TUSER_W-1:0]        s_axis_tuser,
    // result items
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // weight_out[20:0], is_stable[21], zero pad
    output logic [wsd_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    // kind[1:0]
    output logic [wsd_pkg::OUT_TUSER_W-1:0]            m_axis_tuser,
    output logic                                       m_axis_tlast,
    // configuration writes
    input  wire logic                                  i_cfg_we,
    input  wire logic [wsd_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire logic [wsd_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import wsd_pkg::*;

    // configuration
    logic [LEN_CFG_W-1:0]       r_cfg_win;
    logic [TOL_W-1:0]           r_cfg_tol;
    logic [TICK_W-1:0]          r_cfg_to;

    // control state
    t_state                     r_state, n_state;
    logic                       r_armed, n_armed;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [CNT_W-1:0]           r_len, n_len;
    logic [MAG_W-1:0]           r_min, n_min;
    logic [TICK_W-1:0]          r_elapsed, n_elapsed;
    logic                       r_pidx, n_pidx;
    logic                       r_out_valid, n_out_valid;

    // payload
    logic signed [SAMPLE_W-1:0] r_w, n_w;
    logic                       r_to_hit, n_to_hit;
    logic [IDX_W-1:0]           r_k, n_k;
    logic signed [SAMPLE_W-1:0] r_lo, n_lo;
    logic signed [SAMPLE_W-1:0] r_hi, n_hi;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    t_result                    r_pend [2];
    t_result                    n_pend [2];
    t_result                    r_out, n_out;

    // input decode
    logic                       accept_in;
    logic [OP_W-1:0]            op;
    logic signed [SAMPLE_W-1:0] in_w;
    logic [MAG_W-1:0]           in_min;

    // sample qualification
    logic                       fill_zero;
    logic [CNT_W-1:0]           len_eff;
    logic [TICK_W-1:0]          el_eff;
    logic [SAMPLE_W-1:0]        mag;
    logic                       mag_ok;
    logic [CNT_W-1:0]           fill_next;
    logic                       full_next;
    logic                       to_hit;
    logic [TICK_W-1:0]          el_tick;
    logic                       tick_to;
    logic                       append;

    // scan and judge
    logic signed [SAMPLE_W-1:0] tap;
    logic                       incl;
    logic signed [SAMPLE_W:0]   spread;
    logic                       stable;
    logic                       scan_end;
    logic                       out_free;

    // divider
    logic                       div_start;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_q;

    // window chain
    logic signed [SAMPLE_W-1:0] c_q [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] c_d [WINDOW_MAX];
    logic                       cell_en;

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign op        = s_axis_tuser[OP_W-1:0];
    assign in_w      = s_axis_tdata[SAMPLE_W-1:0];
    assign in_min    = s_axis_tdata[SAMPLE_W+MAG_W-1:SAMPLE_W];

    // sample checks against the window as this item sees it
    assign fill_zero = (r_fill == '0);
    assign len_eff   = fill_zero ? clamp_len(r_cfg_win) : r_len;
    assign el_eff    = fill_zero ? '0 : r_elapsed;
    assign mag       = in_w[SAMPLE_W-1] ? SAMPLE_W'(-in_w) : in_w;
    assign mag_ok    = mag >= {1'b0, r_min};
    assign fill_next = (r_fill < len_eff) ? r_fill + 1'b1 : r_fill;
    assign full_next = (fill_next == len_eff);
    assign to_hit    = el_eff > r_cfg_to;
    assign append    = accept_in && (op == OP_SAMPLE) && r_armed && mag_ok;

    // tick counting, saturating
    assign el_tick = (r_fill != '0 && r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
    assign tick_to = r_armed && (el_tick > r_cfg_to);

    // scan tap: cell k steps from the end holds window index WINDOW_MAX-1-k
    assign tap      = c_q[WINDOW_MAX-1];
    assign incl     = ((CNT_W+1)'(r_k) + (CNT_W+1)'(r_len)) >= (CNT_W+1)'(WINDOW_MAX);
    assign scan_end = (r_k == IDX_W'(WINDOW_MAX - 1));
    assign spread   = {r_hi[SAMPLE_W-1], r_hi} - {r_lo[SAMPLE_W-1], r_lo};
    assign stable   = $unsigned(spread) <= (SAMPLE_W+1)'(r_cfg_tol);
    assign out_free = !r_out_valid || m_axis_tready;

    assign div_start = (r_state == S_CHECK) && stable;
    assign cell_en   = append || (r_state == S_SCAN);

    // chain of window cells, newest in cell 0, rotating during the scan
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign c_d[g] = (r_state == S_SCAN) ? tap : in_w;
        end else begin : g_body
            assign c_d[g] = c_q[g-1];
        end
        wsd_cell u_cell (
            .i_clk (i_clk),
            .i_en  (cell_en),
            .i_d   (c_d[g]),
            .o_q   (c_q[g])
        );
    end

    // serial divider for the window mean
    wsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (op == OP_SAMPLE && r_armed) begin
                        if (mag_ok && full_next) begin
                            n_state = S_SCAN;
                        end else if (mag_ok || to_hit) begin
                            n_state = S_EMIT;
                        end
                    end else if (op == OP_TICK && tick_to) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = stable ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free && r_pend[r_pidx].last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state updates and results
    always_comb begin
        n_armed     = r_armed;
        n_fill      = r_fill;
        n_len       = r_len;
        n_min       = r_min;
        n_elapsed   = r_elapsed;
        n_pidx      = r_pidx;
        n_out_valid = r_out_valid;
        n_w         = r_w;
        n_to_hit    = r_to_hit;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_sum       = r_sum;
        n_pend      = r_pend;
        n_out       = r_out;

        // output register drains
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_pidx = 1'b0;
                    unique case (op)
                        OP_SAMPLE: begin
                            if (r_armed) begin
                                if (fill_zero) begin
                                    n_len     = len_eff;
                                    n_elapsed = '0;
                                end
                                if (mag_ok) begin
                                    n_fill   = fill_next;
                                    n_w      = in_w;
                                    n_to_hit = to_hit;
                                    n_k      = '0;
                                    n_lo     = {1'b0, {(SAMPLE_W-1){1'b1}}};
                                    n_hi     = {1'b1, {(SAMPLE_W-1){1'b0}}};
                                    n_sum    = '0;
                                    if (!full_next) begin
                                        n_pend[0] = '{kind: KIND_READING, weight: in_w,
                                                      stable: 1'b0, last: !to_hit};
                                        n_pend[1] = RES_TIMEOUT;
                                        if (to_hit) begin
                                            n_armed = 1'b0;
                                        end
                                    end
                                end else if (to_hit) begin
                                    n_pend[0] = RES_TIMEOUT;
                                    n_armed   = 1'b0;
                                end
                            end
                        end
                        OP_TICK: begin
                            n_elapsed = el_tick;
                            if (tick_to) begin
                                n_pend[0] = RES_TIMEOUT;
                                n_armed   = 1'b0;
                            end
                        end
                        OP_START: begin
                            n_min     = in_min;
                            n_fill    = '0;
                            n_elapsed = '0;
                            n_armed   = 1'b1;
                        end
                        OP_CONTINUE: begin
                            n_min   = in_min;
                            n_armed = 1'b1;
                        end
                        OP_CANCEL: begin
                            n_armed = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // fold the tap into spread and sum when inside the window
                n_k = r_k + 1'b1;
                if (incl) begin
                    if (tap < r_lo) begin
                        n_lo = tap;
                    end
                    if (tap > r_hi) begin
                        n_hi = tap;
                    end
                    n_sum = r_sum + {{(SUM_W-SAMPLE_W){tap[SAMPLE_W-1]}}, tap};
                end
            end
            S_CHECK: begin
                n_pidx = 1'b0;
                if (stable) begin
                    n_pend[0] = '{kind: KIND_READING, weight: r_w, stable: 1'b1, last: 1'b0};
                    n_elapsed = '0;
                    n_armed   = 1'b0;
                end else begin
                    n_pend[0] = '{kind: KIND_READING, weight: r_w,
                                  stable: 1'b0, last: !r_to_hit};
                    n_pend[1] = RES_TIMEOUT;
                    if (r_to_hit) begin
                        n_armed = 1'b0;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_pend[1] = '{kind: KIND_MEAN, weight: div_q, stable: 1'b1, last: 1'b1};
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_pend[r_pidx];
                    n_out_valid = 1'b1;
                    n_pidx      = !r_pidx;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_fill      <= '0;
            r_len       <= CNT_W'(WINDOW_MAX);
            r_min       <= '0;
            r_elapsed   <= '0;
            r_pidx      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_win   <= WINDOW_SAMPLES_RST;
            r_cfg_tol   <= TOLERANCE_RST;
            r_cfg_to    <= TIMEOUT_TICKS_RST;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_min       <= n_min;
            r_elapsed   <= n_elapsed;
            r_pidx      <= n_pidx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_WINDOW_SAMPLES: r_cfg_win <= i_cfg_wdata[LEN_CFG_W-1:0];
                    CFG_TOLERANCE:      r_cfg_tol <= i_cfg_wdata[TOL_W-1:0];
                    CFG_TIMEOUT_TICKS:  r_cfg_to  <= i_cfg_wdata[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_to_hit <= n_to_hit;
        r_k      <= n_k;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_sum    <= n_sum;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    // ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-SAMPLE_W-1){1'b0}}, r_out.stable, r_out.weight};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// File: design/wsd_cell.sv
`default_nettype none

module wsd_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [wsd_pkg::SAMPLE_W-1:0]  i_d,
    output logic signed [wsd_pkg::SAMPLE_W-1:0]       o_q
);
    import wsd_pkg::*;

    logic signed [SAMPLE_W-1:0] r_q;

    // one window slot, takes its neighbor's value on a shift
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: design/wsd_div.sv
`default_nettype none

module wsd_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [wsd_pkg::SUM_W-1:0]     i_dividend,
    input  wire logic [wsd_pkg::CNT_W-1:0]            i_divisor,
    output logic                                      o_done,
    output logic signed [wsd_pkg::SAMPLE_W-1:0]      o_quotient
);
    import wsd_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_div;
    logic [SUM_W-1:0]       r_quo;
    logic                   r_neg;

    logic [CNT_W:0]         shifted;
    logic                   fits;
    logic [CNT_W-1:0]       rem_next;
    logic [SAMPLE_W-1:0]    quo_lo;

    // one restoring step per cycle on the magnitude
    assign shifted  = {r_rem, r_quo[SUM_W-1]};
    assign fits     = shifted >= {1'b0, r_div};
    assign rem_next = fits ? CNT_W'(shifted - {1'b0, r_div}) : CNT_W'(shifted);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= DIV_CNT_W'(SUM_W - 1);
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // truncate toward zero: negate the magnitude quotient
    assign quo_lo     = r_quo[SAMPLE_W-1:0];
    assign o_quotient = r_neg ? SAMPLE_W'(-quo_lo) : quo_lo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// File: design/wsd_checker.sv
`default_nettype none

`include "assert_macros.svh"

module wsd_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    input  wire logic                                  s_axis_tready,
    input  wire logic [wsd_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    input  wire logic [wsd_pkg::IN_TUSER_W-1:0]        s_axis_tuser,
    input  wire logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic [wsd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic [wsd_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
    input  wire logic                                  m_axis_tlast,
    input  wire logic                                  i_cfg_we,
    input  wire logic [wsd_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire logic [wsd_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import wsd_pkg::*;

    // a timeout carries no weight and closes its item
    `WSD_ASSERT(a_timeout_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == KIND_TIMEOUT |-> m_axis_tdata == '0 && m_axis_tlast, "timeout result not clean")

    // a mean is always stable and the last result
    `WSD_ASSERT(a_mean_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == KIND_MEAN |-> m_axis_tlast && m_axis_tdata[SAMPLE_W], "mean result not stable or not last")

    // a stable reading is never marked last, as its mean follows it
    `WSD_ASSERT_NEVER(a_stable_pair, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == KIND_READING && m_axis_tdata[SAMPLE_W] && m_axis_tlast, "stable reading marked last")

    // no new item while a result of the current one is still to come
    `WSD_ASSERT(a_hold_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input taken with results still pending")

    // a stalled result holds
    `WSD_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind weight_stability_detector wsd_checker u_wsd_checker (.*);

`default_nettype wire
